@@ rtl/bmvp_pkg.sv @@
// Shared types, constants and helpers for the banked memory map with VRAM planes.
// No dependencies; every file of the block but bmvp_ram imports this package.
package bmvp_pkg;

    localparam int BIOS_BYTES  = 16384;
    localparam int BASIC_BYTES = 32768;
    localparam int ROM_BYTES   = BIOS_BYTES + BASIC_BYTES;
    localparam int PLANE_BYTES = 16384;
    localparam int RAM_BYTES   = 65536;
    localparam int PLANE_COUNT = 3;

    localparam int ROM_AW   = $clog2(ROM_BYTES);
    localparam int PLANE_AW = $clog2(PLANE_BYTES);
    localparam int RAM_AW   = $clog2(RAM_BYTES);

    // Request types.
    localparam logic [2:0] REQ_MEM_READ  = 3'd0;
    localparam logic [2:0] REQ_MEM_WRITE = 3'd1;
    localparam logic [2:0] REQ_BANK_PORT = 3'd2;
    localparam logic [2:0] REQ_PLANE_SEL = 3'd3;
    localparam logic [2:0] REQ_ATTR      = 3'd4;
    localparam logic [2:0] REQ_PORT_C    = 3'd5;
    localparam logic [2:0] REQ_ROM_LOAD  = 3'd6;

    // Map modes.
    localparam logic [1:0] MAP_BOOT       = 2'd0;
    localparam logic [1:0] MAP_BASIC_BIOS = 2'd1;
    localparam logic [1:0] MAP_ALL_RAM    = 2'd2;
    localparam logic [1:0] MAP_BASIC      = 2'd3;

    // Source of the read data for a word in flight.
    localparam logic [2:0] SRC_ZERO  = 3'd0;
    localparam logic [2:0] SRC_ROM   = 3'd1;
    localparam logic [2:0] SRC_RAM   = 3'd2;
    localparam logic [2:0] SRC_PAL   = 3'd3;
    localparam logic [2:0] SRC_PLANE = 3'd4;

    // One word between the decode stage and the result register.
    typedef struct packed {
        logic [2:0]             src;
        logic [3:0]             pal;
        logic [PLANE_COUNT-1:0] rd_planes;
        logic                   attr_load;
        logic                   pbs;
        logic [3:0]             pb_attr;
        logic                   ios;
        logic                   pcs;
        logic [1:0]             pcv;
    } stage_t;

    // Write and read commands for all memories in one cycle.
    typedef struct packed {
        logic                              rd_en;
        logic                              main_we;
        logic [RAM_AW-1:0]                 main_waddr;
        logic [7:0]                        main_wdata;
        logic [RAM_AW-1:0]                 main_raddr;
        logic                              rom_we;
        logic [ROM_AW-1:0]                 rom_waddr;
        logic [7:0]                        rom_wdata;
        logic [ROM_AW-1:0]                 rom_raddr;
        logic [PLANE_COUNT-1:0]            plane_we;
        logic [PLANE_AW-1:0]               plane_waddr;
        logic [PLANE_COUNT-1:0][7:0]       plane_wdata;
        logic [PLANE_AW-1:0]               plane_raddr;
        logic                              attr_we;
        logic [3:0]                        attr_wdata;
    } mem_cmd_t;

    // Registered read data of all memories.
    typedef struct packed {
        logic [7:0]                  main;
        logic [7:0]                  rom;
        logic [PLANE_COUNT-1:0][7:0] plane;
        logic [3:0]                  attr;
    } mem_rd_t;

    // Attribute bit 3 goes to port B bit 7, bits 2:0 stay in place.
    function automatic logic [7:0] port_b_of(input logic [3:0] attr);
        return {attr[3], 4'b0000, attr[2:0]};
    endfunction

endpackage

@@ rtl/banked_memory_with_vram_planes.sv @@
// Top level of the banked memory map with VRAM planes.
// Depends on bmvp_pkg, bmvp_ram, bmvp_ctrl and bmvp_result.

// This block is the memory map of an 8-bit computer. Each input word is one CPU
// memory read or write, a bank-control port write, a plane-select, attribute or
// port C signal event, or one ROM load byte, and each word produces exactly one
// result word. A new word is accepted in every cycle while in_ready is high: the
// memories are addressed and written at the accepting edge, their registered read
// data is combined with the decoded word held in the stage register, and the
// result lands in the output register once that register is free. The output
// register decouples the two sides: while a result waits to be taken, one more
// word still enters the stage register, and only then does in_ready drop. After
// reset the block runs a clearing pass over every address, one address per cycle
// across all memories (main RAM, colour planes and attribute plane to zero, ROM
// to 0xff), and keeps in_ready low until it completes. Memory writes take effect
// at the accepting edge, so a read that follows a write in the next cycle sees
// the new data. The attribute latch loaded by a plane read is forwarded to a
// plane write that follows it directly, which keeps hold mode exact at full rate.
module banked_memory_with_vram_planes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        port_b_strobe,
    output logic [7:0]  port_b_value,
    output logic        io_mem_strobe,
    output logic        port_c_strobe,
    output logic [1:0]  port_c_value
);
    import bmvp_pkg::*;

    logic     s1_valid;
    stage_t   s1;
    mem_cmd_t cmd;
    mem_rd_t  rd;
    logic     can_take;

    bmvp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .address    (address),
        .data       (data),
        .can_take   (can_take),
        .attr_rdata (rd.attr),
        .s1_valid   (s1_valid),
        .s1         (s1),
        .cmd        (cmd)
    );

    // Main RAM, 64K x 8.
    bmvp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_main_ram (
        .clk   (clk),
        .we    (cmd.main_we),
        .waddr (cmd.main_waddr),
        .wdata (cmd.main_wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.main_raddr),
        .rdata (rd.main)
    );

    // BIOS followed by BASIC.
    bmvp_ram #(
        .WIDTH (8),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .clk   (clk),
        .we    (cmd.rom_we),
        .waddr (cmd.rom_waddr),
        .wdata (cmd.rom_wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rom_raddr),
        .rdata (rd.rom)
    );

    // One memory per colour plane so all three are read in the same cycle.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        bmvp_ram #(
            .WIDTH (8),
            .DEPTH (PLANE_BYTES)
        ) u_plane (
            .clk   (clk),
            .we    (cmd.plane_we[p]),
            .waddr (cmd.plane_waddr),
            .wdata (cmd.plane_wdata[p]),
            .re    (cmd.rd_en),
            .raddr (cmd.plane_raddr),
            .rdata (rd.plane[p])
        );
    end

    // Attribute plane, shares the plane addressing.
    bmvp_ram #(
        .WIDTH (4),
        .DEPTH (PLANE_BYTES)
    ) u_attr (
        .clk   (clk),
        .we    (cmd.attr_we),
        .waddr (cmd.plane_waddr),
        .wdata (cmd.attr_wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.plane_raddr),
        .rdata (rd.attr)
    );

    bmvp_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1            (s1),
        .rd            (rd),
        .can_take      (can_take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .port_b_strobe (port_b_strobe),
        .port_b_value  (port_b_value),
        .io_mem_strobe (io_mem_strobe),
        .port_c_strobe (port_c_strobe),
        .port_c_value  (port_c_value)
    );

endmodule

@@ rtl/bmvp_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module bmvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bmvp_ctrl.sv @@
// Input decode, bank and video state, clearing sequencer and the stage register.
// Depends on bmvp_pkg.
module bmvp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic [15:0]       address,
    input  logic [7:0]        data,
    input  logic              can_take,
    input  logic [3:0]        attr_rdata,
    output logic              s1_valid,
    output bmvp_pkg::stage_t  s1,
    output bmvp_pkg::mem_cmd_t cmd
);
    import bmvp_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_reg, s1_next;
    logic [1:0]       map_mode_reg, map_mode_next;
    logic             window_reg, window_next;
    logic [7:0]       plane_sel_reg, plane_sel_next;
    logic [3:0]       attr_pending_reg, attr_pending_next;
    logic [3:0]       attr_held_reg, attr_held_next;
    logic             hold_mode_reg, hold_mode_next;
    logic             pal_sel_reg, pal_sel_next;
    logic [3:0]       palette_reg [16];
    logic             clear_reg, clear_next;
    logic [RAM_AW-1:0] clr_addr_reg, clr_addr_next;

    logic             acc;
    logic             s1_take;
    logic             in_window;
    logic             pal_acc;
    logic             held_eff;
    logic [3:0]       held_fwd;
    logic [3:0]       held_new;
    logic             pal_we;
    logic             plane_path;
    mem_cmd_t         cmd_c;

    assign in_ready = !clear_reg && (!s1_valid_reg || can_take);
    assign acc      = in_valid && in_ready;
    assign s1_take  = s1_valid_reg && can_take;
    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;
    assign cmd      = cmd_c;

    assign in_window  = window_reg && (address[15:14] == 2'b10);
    assign pal_acc    = pal_sel_reg && (plane_sel_reg[6:4] == 3'b000);
    assign plane_path = in_window && !pal_acc;

    // A plane read still in the stage register has not yet committed its attribute.
    assign held_eff = s1_valid_reg && s1_reg.attr_load;
    assign held_fwd = held_eff ? attr_rdata : attr_held_reg;
    assign held_new = hold_mode_reg ? held_fwd : attr_pending_reg;

    assign pal_we = acc && (req_type == REQ_MEM_WRITE) && in_window && pal_acc;

    always_comb
    begin
        s1_valid_next     = s1_valid_reg;
        s1_next           = s1_reg;
        map_mode_next     = map_mode_reg;
        window_next       = window_reg;
        plane_sel_next    = plane_sel_reg;
        attr_pending_next = attr_pending_reg;
        attr_held_next    = attr_held_reg;
        hold_mode_next    = hold_mode_reg;
        pal_sel_next      = pal_sel_reg;
        clear_next        = clear_reg;
        clr_addr_next     = clr_addr_reg;

        cmd_c             = '0;
        cmd_c.rd_en       = acc;
        cmd_c.main_raddr  = address;
        cmd_c.plane_raddr = address[PLANE_AW-1:0];
        cmd_c.main_waddr  = address;
        cmd_c.main_wdata  = data;
        cmd_c.rom_waddr   = address[ROM_AW-1:0];
        cmd_c.rom_wdata   = data;
        cmd_c.plane_waddr = address[PLANE_AW-1:0];
        cmd_c.attr_wdata  = held_new;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            cmd_c.plane_wdata[p] = plane_sel_reg[p] ? data : 8'hff;
        end

        if (map_mode_reg == MAP_BOOT)
        begin
            cmd_c.rom_raddr = ROM_AW'(address[13:0]);
        end
        else if ((map_mode_reg == MAP_BASIC_BIOS) && address[14])
        begin
            cmd_c.rom_raddr = ROM_AW'(address[13:0]);
        end
        else
        begin
            cmd_c.rom_raddr = ROM_AW'(BIOS_BYTES) + ROM_AW'(address[14:0]);
        end

        if (s1_take)
        begin
            s1_valid_next = 1'b0;
            if (s1_reg.attr_load)
            begin
                attr_held_next = attr_rdata;
            end
        end

        if (acc)
        begin
            s1_valid_next = 1'b1;
            s1_next       = '0;
            s1_next.pal   = palette_reg[address[3:0]];
            case (req_type)
                REQ_MEM_READ:
                begin
                    if (in_window)
                    begin
                        if (pal_acc)
                        begin
                            s1_next.src = SRC_PAL;
                        end
                        else
                        begin
                            s1_next.src = SRC_PLANE;
                            for (int p = 0; p < PLANE_COUNT; p++)
                            begin
                                s1_next.rd_planes[p] = plane_sel_reg[p] && plane_sel_reg[p + 4];
                            end
                            s1_next.attr_load = plane_sel_reg[2] && plane_sel_reg[6];
                            s1_next.pbs       = plane_sel_reg[2] && plane_sel_reg[6];
                        end
                    end
                    else if (map_mode_reg == MAP_BOOT)
                    begin
                        s1_next.src = SRC_ROM;
                    end
                    else if (!address[15] && (map_mode_reg != MAP_ALL_RAM))
                    begin
                        s1_next.src = SRC_ROM;
                    end
                    else
                    begin
                        s1_next.src = SRC_RAM;
                    end
                end
                REQ_MEM_WRITE:
                begin
                    if (plane_path)
                    begin
                        for (int p = 0; p < PLANE_COUNT; p++)
                        begin
                            cmd_c.plane_we[p] = plane_sel_reg[p + 4];
                        end
                        if (plane_sel_reg[6])
                        begin
                            cmd_c.attr_we   = 1'b1;
                            attr_held_next  = held_new;
                            s1_next.pbs     = 1'b1;
                            s1_next.pb_attr = held_new;
                        end
                    end
                    else if (!in_window && (map_mode_reg != MAP_BOOT))
                    begin
                        cmd_c.main_we = 1'b1;
                    end
                end
                REQ_BANK_PORT:
                begin
                    map_mode_next = data[0] ? MAP_BASIC_BIOS :
                                    data[1] ? MAP_ALL_RAM : MAP_BASIC;
                    window_next   = data[2];
                    s1_next.ios   = data[3];
                    s1_next.pcs   = 1'b1;
                    s1_next.pcv   = data[1:0];
                end
                REQ_PLANE_SEL:
                begin
                    plane_sel_next = data;
                end
                REQ_ATTR:
                begin
                    attr_pending_next = data[3:0];
                end
                REQ_PORT_C:
                begin
                    hold_mode_next = data[4];
                    pal_sel_next   = |data[3:2];
                end
                REQ_ROM_LOAD:
                begin
                    cmd_c.rom_we = (32'(address) < ROM_BYTES);
                end
                default:
                begin
                end
            endcase
        end

        // The clearing pass owns every write port until it finishes.
        if (clear_reg)
        begin
            cmd_c.main_we     = 1'b1;
            cmd_c.main_waddr  = clr_addr_reg;
            cmd_c.main_wdata  = 8'h00;
            cmd_c.rom_we      = (32'(clr_addr_reg) < ROM_BYTES);
            cmd_c.rom_waddr   = clr_addr_reg[ROM_AW-1:0];
            cmd_c.rom_wdata   = 8'hff;
            cmd_c.plane_we    = '1;
            cmd_c.plane_waddr = clr_addr_reg[PLANE_AW-1:0];
            cmd_c.plane_wdata = '0;
            cmd_c.attr_we     = 1'b1;
            cmd_c.attr_wdata  = 4'h0;
            clr_addr_next     = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            map_mode_reg     <= MAP_BOOT;
            window_reg       <= 1'b0;
            plane_sel_reg    <= 8'h00;
            attr_pending_reg <= 4'h0;
            attr_held_reg    <= 4'h0;
            hold_mode_reg    <= 1'b0;
            pal_sel_reg      <= 1'b0;
            clear_reg        <= 1'b1;
            clr_addr_reg     <= '0;
            for (int i = 0; i < 16; i++)
            begin
                palette_reg[i] <= 4'h0;
            end
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            map_mode_reg     <= map_mode_next;
            window_reg       <= window_next;
            plane_sel_reg    <= plane_sel_next;
            attr_pending_reg <= attr_pending_next;
            attr_held_reg    <= attr_held_next;
            hold_mode_reg    <= hold_mode_next;
            pal_sel_reg      <= pal_sel_next;
            clear_reg        <= clear_next;
            clr_addr_reg     <= clr_addr_next;
            if (pal_we)
            begin
                palette_reg[address[3:0]] <= data[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

endmodule

@@ rtl/bmvp_result.sv @@
// Result formation from the stage register and memory read data, and the output register.
// Depends on bmvp_pkg.
module bmvp_result (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  bmvp_pkg::stage_t  s1,
    input  bmvp_pkg::mem_rd_t rd,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_data,
    output logic              port_b_strobe,
    output logic [7:0]        port_b_value,
    output logic              io_mem_strobe,
    output logic              port_c_strobe,
    output logic [1:0]        port_c_value
);
    import bmvp_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] rd_reg, rd_next;
    logic       pbs_reg;
    logic [7:0] pbv_reg, pbv_next;
    logic       ios_reg, pcs_reg;
    logic [1:0] pcv_reg;
    logic [7:0] plane_and;
    logic [3:0] pb_attr;
    logic       load;

    assign can_take = !out_valid_reg || out_ready;
    assign load     = s1_valid && can_take;

    always_comb
    begin
        plane_and = 8'hff;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            if (s1.rd_planes[p])
            begin
                plane_and = plane_and & rd.plane[p];
            end
        end

        case (s1.src)
            SRC_ROM:   rd_next = rd.rom;
            SRC_RAM:   rd_next = rd.main;
            SRC_PAL:   rd_next = {4'h0, s1.pal};
            SRC_PLANE: rd_next = plane_and;
            default:   rd_next = 8'h00;
        endcase

        pb_attr  = s1.attr_load ? rd.attr : s1.pb_attr;
        pbv_next = s1.pbs ? port_b_of(pb_attr) : 8'h00;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg  <= rd_next;
            pbs_reg <= s1.pbs;
            pbv_reg <= pbv_next;
            ios_reg <= s1.ios;
            pcs_reg <= s1.pcs;
            pcv_reg <= s1.pcs ? s1.pcv : 2'b00;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = rd_reg;
    assign port_b_strobe = pbs_reg;
    assign port_b_value  = pbv_reg;
    assign io_mem_strobe = ios_reg;
    assign port_c_strobe = pcs_reg;
    assign port_c_value  = pcv_reg;

endmodule

@@ tb/sv/banked_memory_with_vram_planes_tb.sv @@
// Self-checking testbench for banked_memory_with_vram_planes: a directed table, then random bus words.
// Depends on bmvp_pkg and the banked_memory_with_vram_planes RTL; needs no other file.
module banked_memory_with_vram_planes_tb;
    import bmvp_pkg::*;

    // The only request code the package leaves out; the block must answer it with zeros.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // The slowest correct run is the clearing pass plus roughly 1400 words, each with
    // the longest sender gap, the longest receiver stall and the latency of the block,
    // plus one long hold-off. This limit leaves several times the margin over such a
    // run.
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned RANDOM_WORDS = 1350;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 400;

    // One result word, laid out field by field as the output ports.
    typedef struct packed {
        logic [7:0] rd_byte;
        logic       pb_strobe;
        logic [7:0] pb_value;
        logic       io_strobe;
        logic       pc_strobe;
        logic [1:0] pc_value;
    } bus_result_t;

    localparam bus_result_t NO_OUTPUT = '0;

    // A row of the directed table. When typed is set, want holds the result read
    // straight off the behavior; otherwise the word is checked against the predictor.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  value;
        logic        typed;
        bus_result_t want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 26;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [15:0] address;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        port_b_strobe;
    logic [7:0]  port_b_value;
    logic        io_mem_strobe;
    logic        port_c_strobe;
    logic [1:0]  port_c_value;

    banked_memory_with_vram_planes dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .address       (address),
        .data          (data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .port_b_strobe (port_b_strobe),
        .port_b_value  (port_b_value),
        .io_mem_strobe (io_mem_strobe),
        .port_c_strobe (port_c_strobe),
        .port_c_value  (port_c_value)
    );

    // Shadow copy of everything the memory map remembers. The predictor below
    // updates it word by word in the order the block accepts the words.
    logic [7:0] ram_img   [RAM_BYTES];
    logic [7:0] plane_img [PLANE_COUNT][PLANE_BYTES];
    logic [3:0] attr_img  [PLANE_BYTES];
    logic [7:0] rom_img   [ROM_BYTES];
    logic [3:0] pal_img   [16];
    logic [1:0] map_mode;
    logic       window_open;
    logic [7:0] plane_sel;
    logic [3:0] attr_pending;
    logic [3:0] held_attr;
    logic       attr_hold;
    logic       pal_sel;

    // Results owed by the block, oldest first.
    bus_result_t results_due [$];
    bus_result_t head_word;

    directed_row_t directed [DIRECTED_ROWS];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned words_sent;
    int unsigned words_acted;
    int unsigned read_words;
    int unsigned write_words;
    int unsigned window_words;
    int unsigned port_words;
    bit          calm;
    bit          hold_done;

    // Free-running clock with a period of two time units.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL banked_memory_with_vram_planes");
            $finish;
        end
    end

    // Gap length shared by sender and receiver: mostly none or short, a few long,
    // and none at all while a calm stretch is running.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // CPU address inside one 16KB quarter. Offsets cluster at the bottom and top
    // of the quarter so that reads keep landing on bytes written earlier, and the
    // low four bits double as palette indexes.
    function automatic logic [15:0] pick_cpu_addr(input logic [1:0] quarter);
        int          roll;
        logic [13:0] offset;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            offset = 14'($urandom_range(0, 15));
        else if (roll < 90)
            offset = 14'h3FF0 | 14'($urandom_range(0, 15));
        else
            offset = 14'($urandom);
        return {quarter, offset};
    endfunction

    // ROM load index: BIOS bytes, BASIC bytes at the same offsets the CPU map
    // reaches, a few out of range, and a few anywhere.
    function automatic logic [15:0] pick_rom_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return pick_cpu_addr(2'b00);
        if (roll < 80)
            return 16'(BIOS_BYTES) + pick_cpu_addr({1'b0, 1'($urandom)});
        if (roll < 90)
            return 16'(ROM_BYTES) + 16'($urandom_range(0, 16383));
        return 16'($urandom);
    endfunction

    // Predictor of the memory map. It applies one accepted word to the shadow
    // state and returns the result word the block must produce for it. acted is
    // cleared for words the block simply ignores.
    function automatic void apply_bus_word(input logic [2:0] kind, input logic [15:0] addr,
                                           input logic [7:0] value, output bus_result_t res,
                                           output bit acted);
        logic        in_window;
        logic        pal_path;
        logic [13:0] laddr;
        logic [7:0]  planes_and;
        res       = NO_OUTPUT;
        acted     = 1'b1;
        in_window = window_open && (addr[15:14] == 2'b10);
        pal_path  = pal_sel && (plane_sel[6:4] == 3'b000);
        laddr     = addr[13:0];
        if (in_window && (kind == REQ_MEM_READ || kind == REQ_MEM_WRITE))
            window_words++;
        case (kind)
            REQ_MEM_READ:
            begin
                if (in_window)
                begin
                    if (pal_path)
                        res.rd_byte = {4'h0, pal_img[addr[3:0]]};
                    else
                    begin
                        // Start from all ones and AND in every plane that is both
                        // enabled and selected for reading.
                        planes_and = 8'hFF;
                        if (plane_sel[4] && plane_sel[0])
                            planes_and &= plane_img[0][laddr];
                        if (plane_sel[5] && plane_sel[1])
                            planes_and &= plane_img[1][laddr];
                        if (plane_sel[6] && plane_sel[2])
                        begin
                            held_attr       = attr_img[laddr];
                            planes_and     &= plane_img[2][laddr];
                            res.pb_strobe   = 1'b1;
                            res.pb_value    = {held_attr[3], 4'h0, held_attr[2:0]};
                        end
                        res.rd_byte = planes_and;
                    end
                end
                else if (map_mode == MAP_BOOT)
                    res.rd_byte = rom_img[int'(addr[13:0])];
                else if (!addr[15] && map_mode != MAP_ALL_RAM)
                begin
                    if (map_mode == MAP_BASIC_BIOS && addr[14])
                        res.rd_byte = rom_img[int'(addr[13:0])];
                    else
                        res.rd_byte = rom_img[BIOS_BYTES + int'(addr[14:0])];
                end
                else
                    res.rd_byte = ram_img[int'(addr)];
            end
            REQ_MEM_WRITE:
            begin
                if (in_window)
                begin
                    if (pal_path)
                        pal_img[addr[3:0]] = value[3:0];
                    else
                    begin
                        // An enabled plane without its data bit is filled with ones.
                        if (plane_sel[4])
                            plane_img[0][laddr] = plane_sel[0] ? value : 8'hFF;
                        if (plane_sel[5])
                            plane_img[1][laddr] = plane_sel[1] ? value : 8'hFF;
                        if (plane_sel[6])
                        begin
                            plane_img[2][laddr] = plane_sel[2] ? value : 8'hFF;
                            if (!attr_hold)
                                held_attr = attr_pending;
                            attr_img[laddr] = held_attr;
                            res.pb_strobe   = 1'b1;
                            res.pb_value    = {held_attr[3], 4'h0, held_attr[2:0]};
                        end
                    end
                end
                else if (map_mode != MAP_BOOT)
                    ram_img[int'(addr)] = value;
                else
                    acted = 1'b0;
            end
            REQ_BANK_PORT:
            begin
                map_mode      = value[0] ? MAP_BASIC_BIOS : (value[1] ? MAP_ALL_RAM : MAP_BASIC);
                window_open   = value[2];
                res.io_strobe = value[3];
                res.pc_strobe = 1'b1;
                res.pc_value  = value[1:0];
            end
            REQ_PLANE_SEL:
                plane_sel = value;
            REQ_ATTR:
                attr_pending = value[3:0];
            REQ_PORT_C:
            begin
                attr_hold = value[4];
                pal_sel   = |value[3:2];
            end
            REQ_ROM_LOAD:
            begin
                if (int'(addr) < ROM_BYTES)
                    rom_img[int'(addr)] = value;
                else
                    acted = 1'b0;
            end
            default:
                acted = 1'b0;
        endcase
    endfunction

    // Offers one word after a random gap and holds it until the block takes it.
    // The handshake is sampled right after the edge, before any nonblocking
    // update of that edge lands, so both sides see the same pre-edge values.
    // The expected result is queued in the same time step as the acceptance.
    task automatic drive_word(input logic [2:0] kind, input logic [15:0] addr,
                              input logic [7:0] value, input bit typed,
                              input bus_result_t want);
        int          gap;
        bus_result_t predicted;
        bit          acted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        address  <= addr;
        data     <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_bus_word(kind, addr, value, predicted, acted);
        results_due.push_back(typed ? want : predicted);
        words_sent++;
        if (acted)
            words_acted++;
        if (kind == REQ_MEM_READ)
            read_words++;
        else if (kind == REQ_MEM_WRITE)
            write_words++;
        else if (kind != REQ_ROM_LOAD && kind != REQ_UNUSED)
            port_words++;
    endtask

    // CPU access: mostly reads and writes in the given quarter, sometimes anywhere.
    task automatic drive_access(input logic [1:0] quarter);
        logic [2:0]  kind;
        logic [15:0] addr;
        kind = ($urandom_range(0, 99) < 55) ? REQ_MEM_READ : REQ_MEM_WRITE;
        addr = ($urandom_range(0, 9) < 8) ? pick_cpu_addr(quarter) : 16'($urandom);
        drive_word(kind, addr, 8'($urandom), 1'b0, NO_OUTPUT);
    endtask

    // Receiver: random stalls, plus one long hold-off once traffic is flowing so
    // that the output register and the stage fill up and in_ready drops while
    // the sender keeps offering words.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && results_checked >= 400)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Checker: every accepted result is matched against the oldest expectation,
    // field by field. A result with nothing owed is a failure as well.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result word arrived with no expectation waiting");
                mismatches++;
            end
            else
            begin
                head_word = results_due.pop_front();
                results_checked++;
                if (read_data !== head_word.rd_byte)
                begin
                    $error("read_data: expected %h, got %h", head_word.rd_byte, read_data);
                    mismatches++;
                end
                if (port_b_strobe !== head_word.pb_strobe)
                begin
                    $error("port_b_strobe: expected %b, got %b",
                           head_word.pb_strobe, port_b_strobe);
                    mismatches++;
                end
                if (port_b_value !== head_word.pb_value)
                begin
                    $error("port_b_value: expected %h, got %h",
                           head_word.pb_value, port_b_value);
                    mismatches++;
                end
                if (io_mem_strobe !== head_word.io_strobe)
                begin
                    $error("io_mem_strobe: expected %b, got %b",
                           head_word.io_strobe, io_mem_strobe);
                    mismatches++;
                end
                if (port_c_strobe !== head_word.pc_strobe)
                begin
                    $error("port_c_strobe: expected %b, got %b",
                           head_word.pc_strobe, port_c_strobe);
                    mismatches++;
                end
                if (port_c_value !== head_word.pc_value)
                begin
                    $error("port_c_value: expected %h, got %h",
                           head_word.pc_value, port_c_value);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, the directed table, random scenes, then drain.
    initial
    begin
        int          scene;
        int          roll;
        logic [7:0]  sel;
        logic [1:0]  quarter;
        // All inputs start at known values; reset is asserted from time zero.
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_MEM_READ;
        address  = 16'h0000;
        data     = 8'h00;
        cycle_count     = 0;
        mismatches      = 0;
        results_checked = 0;
        words_sent      = 0;
        words_acted     = 0;
        read_words      = 0;
        write_words     = 0;
        window_words    = 0;
        port_words      = 0;
        calm            = 1'b0;
        hold_done       = 1'b0;

        // Shadow state after reset: RAM and planes zero, ROM all ones, boot map.
        foreach (ram_img[i])
            ram_img[i] = 8'h00;
        foreach (plane_img[p, i])
            plane_img[p][i] = 8'h00;
        foreach (attr_img[i])
            attr_img[i] = 4'h0;
        foreach (rom_img[i])
            rom_img[i] = 8'hFF;
        foreach (pal_img[i])
            pal_img[i] = 4'h0;
        map_mode     = MAP_BOOT;
        window_open  = 1'b0;
        plane_sel    = 8'h00;
        attr_pending = 4'h0;
        held_attr    = 4'h0;
        attr_hold    = 1'b0;
        pal_sel      = 1'b0;

        // Directed words. The walk goes: boot-mode reads of unloaded ROM at both
        // ends of the map, ROM loads at the edges of BIOS and BASIC and one past
        // the end, the BIOS mirror, a dropped boot-mode write, an unknown request,
        // then each map mode, plane writes and reads with the attribute latch, hold
        // mode, and finally the palette.
        directed = '{
            '{REQ_MEM_READ,  16'h0000, 8'h00, 1'b1, '{8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0}},
            '{REQ_MEM_READ,  16'hFFFF, 8'h00, 1'b1, '{8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0}},
            '{REQ_ROM_LOAD,  16'h0000, 8'h5A, 1'b1, NO_OUTPUT},
            '{REQ_ROM_LOAD,  16'h4000, 8'h3C, 1'b1, NO_OUTPUT},
            '{REQ_ROM_LOAD,  16'hBFFF, 8'hC3, 1'b1, NO_OUTPUT},
            '{REQ_ROM_LOAD,  16'hC000, 8'h11, 1'b1, NO_OUTPUT},
            '{REQ_MEM_READ,  16'hC000, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_MEM_WRITE, 16'h1234, 8'h77, 1'b1, NO_OUTPUT},
            '{REQ_UNUSED,    16'hFFFF, 8'hFF, 1'b1, NO_OUTPUT},
            '{REQ_BANK_PORT, 16'h0000, 8'h0F, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 2'd3}},
            '{REQ_MEM_READ,  16'h4000, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_MEM_READ,  16'h0000, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_BANK_PORT, 16'h0000, 8'h02, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 2'd2}},
            '{REQ_MEM_WRITE, 16'hFFFF, 8'hFF, 1'b1, NO_OUTPUT},
            '{REQ_MEM_READ,  16'hFFFF, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_BANK_PORT, 16'h0000, 8'h04, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 2'd0}},
            '{REQ_MEM_READ,  16'h7FFF, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_ATTR,      16'h0000, 8'h0B, 1'b1, NO_OUTPUT},
            '{REQ_PLANE_SEL, 16'h0000, 8'h77, 1'b1, NO_OUTPUT},
            '{REQ_MEM_WRITE, 16'h8000, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_MEM_READ,  16'h8000, 8'h00, 1'b0, NO_OUTPUT},
            '{REQ_PORT_C,    16'h0000, 8'h1C, 1'b1, NO_OUTPUT},
            '{REQ_PLANE_SEL, 16'h0000, 8'h70, 1'b1, NO_OUTPUT},
            '{REQ_MEM_WRITE, 16'hBFFF, 8'h12, 1'b0, NO_OUTPUT},
            '{REQ_PLANE_SEL, 16'h0000, 8'h00, 1'b1, NO_OUTPUT},
            '{REQ_MEM_WRITE, 16'h800F, 8'hFA, 1'b0, NO_OUTPUT}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The block runs its clearing pass now; drive_word simply waits on
        // in_ready for it.
        foreach (directed[r])
            drive_word(directed[r].kind, directed[r].addr, directed[r].value,
                       directed[r].typed, directed[r].want);
        // Reading the palette entry just written closes the directed part.
        drive_word(REQ_MEM_READ, 16'hBFFF, 8'h00, 1'b0, NO_OUTPUT);

        // Random scenes. Most are well-formed: a window scene opens the VRAM
        // window, may set up plane select, attribute and port C, then hits the
        // window; a map scene may load ROM bytes and switch the map, then hits one
        // quarter of the address space. The rest is noise over every field.
        scene = 0;
        while (words_acted < RANDOM_WORDS + DIRECTED_ROWS)
        begin
            // Every twentieth stretch of three scenes runs with no idling at all.
            calm = (scene % 20) < 3;
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                drive_word(REQ_BANK_PORT, 16'($urandom), 8'($urandom) | 8'h04,
                           1'b0, NO_OUTPUT);
                if ($urandom_range(0, 3) != 0)
                begin
                    // Clear enables often enough that the palette path is reached.
                    sel = 8'($urandom);
                    if ($urandom_range(0, 9) < 3)
                        sel[6:4] = 3'b000;
                    drive_word(REQ_PLANE_SEL, 16'($urandom), sel, 1'b0, NO_OUTPUT);
                end
                if ($urandom_range(0, 1) != 0)
                    drive_word(REQ_ATTR, 16'($urandom), 8'($urandom), 1'b0, NO_OUTPUT);
                if ($urandom_range(0, 2) == 0)
                    drive_word(REQ_PORT_C, 16'($urandom), 8'($urandom), 1'b0, NO_OUTPUT);
                repeat ($urandom_range(3, 8))
                    drive_access(2'b10);
            end
            else if (roll < 75)
            begin
                repeat ($urandom_range(0, 3))
                    drive_word(REQ_ROM_LOAD, pick_rom_index(), 8'($urandom), 1'b0, NO_OUTPUT);
                if ($urandom_range(0, 1) != 0)
                    drive_word(REQ_BANK_PORT, 16'($urandom), 8'($urandom), 1'b0, NO_OUTPUT);
                quarter = 2'($urandom);
                repeat ($urandom_range(3, 8))
                    drive_access(quarter);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    drive_word(3'($urandom), 16'($urandom), 8'($urandom), 1'b0, NO_OUTPUT);
            end
            scene++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then run on for DRAIN_CYCLES more so that a
        // stray extra result would still be caught.
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d words (%0d with effect): %0d reads, %0d writes, %0d in the VRAM window,",
                 words_sent, words_acted, read_words, write_words, window_words);
        $display("%0d port and signal events; %0d result words checked, %0d mismatches.",
                 port_words, results_checked, mismatches);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASS banked_memory_with_vram_planes");
        else
            $display("FAIL banked_memory_with_vram_planes");
        $finish;
    end

endmodule
